FILE: rtl/core/gsbs_pkg.sv
// shared constants, codes and controller/datapath types for the block statistics engine
`timescale 1ns / 1ps
`default_nettype none

package gsbs_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FILL_WIDTH_DEF    = 24;
  localparam int TIME_WIDTH        = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int BLOCK_SIZE_WIDTH  = 24;
  localparam int INTERVAL_WIDTH    = 29;
  localparam int CFG_DATA_WIDTH    = 29;
  localparam int CFG_INDEX_WIDTH   = 1;
  localparam int GAP_FACTOR        = 10;
  localparam int SMALL_BLOCK       = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLOCK_SIZE      = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_INTERVAL = 1'd1;

  localparam logic KIND_BLOCK  = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_ACCUM,
    ST_FULL,
    ST_EOS,
    ST_CALC_START,
    ST_MUL,
    ST_SQRT_START,
    ST_SQRT,
    ST_DIV_START,
    ST_DIV,
    ST_EMIT_BLOCK,
    ST_EMIT_MARKER
  } state_t;

  typedef enum logic [1:0] {
    CTX_GAP,
    CTX_FULL,
    CTX_EOS
  } ctx_t;

  typedef struct packed {
    logic in_ready;
    logic accum;
    logic calc_start;
    logic mul_step;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic out_load_block;
    logic out_load_marker;
    logic marker_prev;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic gap;
    logic fill_nz;
    logic under_three;
    logic full;
    logic eos;
    logic size_one;
    logic iter_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/gsbs_if.sv
// sample and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface gsbs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  logic signed [31:0] sample_value;
  logic        end_of_series;

  modport source (output valid, output sample_time, output sample_value,
                  output end_of_series, input ready);
  modport sink (input valid, input sample_time, input sample_value,
                input end_of_series, output ready);
endinterface

interface gsbs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] block_time;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic signed [31:0] mean_value;
  logic [31:0] deviation;
  logic signed [31:0] first_value;
  logic        last_result;

  modport source (output valid, output result_kind, output block_time,
                  output min_value, output max_value, output mean_value,
                  output deviation, output first_value, output last_result,
                  input ready);
  modport sink (input valid, input result_kind, input block_time,
                input min_value, input max_value, input mean_value,
                input deviation, input first_value, input last_result,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gsbs_dp.sv
// datapath: config, segment/block accumulators, iterative mul/sqrt/div unit, result register
`timescale 1ns / 1ps
`default_nettype none

module gsbs_dp #(
  parameter int VALUE_WIDTH = gsbs_pkg::VALUE_WIDTH_DEF,
  parameter int FILL_WIDTH  = gsbs_pkg::FILL_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [gsbs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [gsbs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  gsbs_pkg::cmd_t                             cmd,
  output gsbs_pkg::status_t                          status,
  gsbs_in_if.sink                                    sample_in,
  gsbs_out_if.source                                 result_out
);

  localparam int VW = VALUE_WIDTH;
  localparam int FW = FILL_WIDTH;
  localparam int SW = VW + FW;
  localparam int QW = 2 * VW + FW;
  localparam int DW = 2 * SW;
  localparam int CW = $clog2(SW);
  localparam int BW = gsbs_pkg::BLOCK_SIZE_WIDTH;
  localparam int IW = gsbs_pkg::INTERVAL_WIDTH;
  localparam int TW = gsbs_pkg::TIME_WIDTH;
  localparam int OW = gsbs_pkg::FIELD_WIDTH;
  localparam logic [BW-1:0] FILL_MAX = BW'((64'd1 << FILL_WIDTH) - 64'd1);

  // configuration
  logic [BW-1:0] block_size;
  logic [IW-1:0] sample_interval;

  // latched item
  logic [TW-1:0]        t_reg;
  logic signed [VW-1:0] v_reg;
  logic                 eos_reg;
  logic signed [2*VW-1:0] sq_full;
  logic [2*VW-1:0]      sq_reg;

  // segment and block state
  logic [TW-1:0]        previous_time;
  logic                 segment_open;
  logic [FW-1:0]        block_fill;
  logic [TW-1:0]        block_start_time;
  logic signed [VW-1:0] block_first;
  logic signed [VW-1:0] running_min;
  logic signed [VW-1:0] running_max;
  logic signed [SW-1:0] running_sum;
  logic [QW-1:0]        square_sum;

  // iterative unit
  logic [CW-1:0]        cnt;
  logic [DW-1:0]        pn_acc, pn_md, s_acc, s_md;
  logic [FW-1:0]        n_sh;
  logic [SW-1:0]        m_sh;
  logic [SW-1:0]        dvd;
  logic [FW-1:0]        drem;
  logic                 neg;
  logic [DW-1:0]        rad;
  logic [SW+1:0]        rem;
  logic [SW-1:0]        root;
  logic signed [VW-1:0] mean_reg;

  // output register
  logic                 out_valid;
  logic                 o_kind, o_last;
  logic [TW-1:0]        o_time;
  logic signed [OW-1:0] o_min, o_max, o_mean, o_first;
  logic [OW-1:0]        o_dev;

  logic [FW-1:0]        size_eff;
  logic [TW-1:0]        dt;
  logic [TW:0]          gap_limit;
  logic [SW-1:0]        smag;
  logic [FW:0]          drem_sh;
  logic                 dge;
  logic [SW+3:0]        rem_sh, trial;
  logic                 sge;
  logic signed [SW-1:0] mean_full;
  logic                 accept;
  logic                 out_free;

  always_comb begin
    if (block_size == '0) begin
      size_eff = FW'(1);
    end else if (block_size > FILL_MAX) begin
      size_eff = FW'(FILL_MAX);
    end else begin
      size_eff = FW'(block_size);
    end
  end

  assign accept    = sample_in.valid && sample_in.ready;
  assign out_free  = !out_valid || result_out.ready;
  assign dt        = t_reg - previous_time;
  assign gap_limit = (TW + 1)'(sample_interval) * (TW + 1)'(gsbs_pkg::GAP_FACTOR);
  assign sq_full   = v_reg * v_reg;
  assign smag      = running_sum[SW-1] ? SW'(-running_sum) : SW'(running_sum);

  // restoring divider step
  assign drem_sh = {drem, dvd[SW-1]};
  assign dge     = drem_sh >= {1'b0, block_fill};
  // restoring square root step, two radicand bits at a time
  assign rem_sh  = {rem, rad[DW-1:DW-2]};
  assign trial   = (SW + 4)'({root, 2'b01});
  assign sge     = rem_sh >= trial;
  assign mean_full = neg ? -$signed(dvd) : $signed(dvd);

  always_comb begin
    status             = '0;
    status.in_valid    = sample_in.valid;
    status.gap         = segment_open && (t_reg > previous_time) && ({1'b0, dt} > gap_limit);
    status.fill_nz     = block_fill != '0;
    status.under_three = block_fill < FW'(gsbs_pkg::SMALL_BLOCK);
    status.full        = block_fill >= size_eff;
    status.eos         = eos_reg;
    status.size_one    = size_eff == FW'(1);
    status.iter_done   = cnt == CW'(SW - 1);
    status.out_free    = out_free;
  end

  assign sample_in.ready = cmd.in_ready && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size      <= BW'(1);
      sample_interval <= IW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsbs_pkg::REG_BLOCK_SIZE:      block_size      <= BW'(cfg_data);
        gsbs_pkg::REG_SAMPLE_INTERVAL: sample_interval <= IW'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_reg   <= sample_in.sample_time;
      v_reg   <= sample_in.sample_value[VW-1:0];
      eos_reg <= sample_in.end_of_series;
    end
    sq_reg <= $unsigned(sq_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_open  <= 1'b0;
      block_fill    <= '0;
      previous_time <= '0;
    end else if (cmd.accum) begin
      block_fill    <= block_fill + FW'(1);
      segment_open  <= 1'b1;
      previous_time <= t_reg;
    end else if (cmd.out_load_marker) begin
      block_fill   <= '0;
      segment_open <= 1'b0;
    end else if (cmd.out_load_block) begin
      block_fill <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      if (block_fill == '0) begin
        block_start_time <= t_reg;
        block_first      <= v_reg;
        running_min      <= v_reg;
        running_max      <= v_reg;
        running_sum      <= SW'(v_reg);
        square_sum       <= QW'(sq_reg);
      end else begin
        if (v_reg < running_min) begin
          running_min <= v_reg;
        end
        if (v_reg > running_max) begin
          running_max <= v_reg;
        end
        running_sum <= running_sum + SW'(v_reg);
        square_sum  <= square_sum + QW'(sq_reg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_start) begin
      pn_acc <= '0;
      pn_md  <= DW'(square_sum);
      n_sh   <= block_fill;
      s_acc  <= '0;
      s_md   <= DW'(smag);
      m_sh   <= smag;
      dvd    <= smag;
      drem   <= '0;
      neg    <= running_sum[SW-1];
      cnt    <= '0;
    end else if (cmd.sqrt_start) begin
      rad      <= (pn_acc >= s_acc) ? pn_acc - s_acc : '0;
      rem      <= '0;
      root     <= '0;
      cnt      <= '0;
      mean_reg <= VW'(mean_full);
    end else if (cmd.div_start) begin
      dvd  <= root;
      drem <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.mul_step) begin
        pn_acc <= n_sh[0] ? pn_acc + pn_md : pn_acc;
        pn_md  <= {pn_md[DW-2:0], 1'b0};
        n_sh   <= {1'b0, n_sh[FW-1:1]};
        s_acc  <= m_sh[0] ? s_acc + s_md : s_acc;
        s_md   <= {s_md[DW-2:0], 1'b0};
        m_sh   <= {1'b0, m_sh[SW-1:1]};
      end
      if (cmd.div_step) begin
        drem <= dge ? FW'(drem_sh - {1'b0, block_fill}) : FW'(drem_sh);
        dvd  <= {dvd[SW-2:0], dge};
      end
      if (cmd.sqrt_step) begin
        rem  <= sge ? (SW + 2)'(rem_sh - trial) : (SW + 2)'(rem_sh);
        root <= {root[SW-2:0], sge};
        rad  <= {rad[DW-3:0], 2'b00};
      end
      if (cmd.mul_step || cmd.div_step || cmd.sqrt_step) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load_block || cmd.out_load_marker) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_marker) begin
      o_kind  <= gsbs_pkg::KIND_MARKER;
      o_time  <= cmd.marker_prev ? previous_time : t_reg;
      o_min   <= '0;
      o_max   <= '0;
      o_mean  <= '0;
      o_dev   <= '0;
      o_first <= '0;
      o_last  <= cmd.out_last;
    end else if (cmd.out_load_block) begin
      o_kind  <= gsbs_pkg::KIND_BLOCK;
      o_time  <= block_start_time;
      o_first <= OW'(block_first);
      o_last  <= cmd.out_last;
      if (status.under_three) begin
        o_min  <= OW'(block_first);
        o_max  <= OW'(block_first);
        o_mean <= OW'(block_first);
        o_dev  <= '0;
      end else begin
        o_min  <= OW'(running_min);
        o_max  <= OW'(running_max);
        o_mean <= OW'(mean_reg);
        o_dev  <= OW'(dvd);
      end
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.result_kind = o_kind;
  assign result_out.block_time  = o_time;
  assign result_out.min_value   = o_min;
  assign result_out.max_value   = o_max;
  assign result_out.mean_value  = o_mean;
  assign result_out.deviation   = o_dev;
  assign result_out.first_value = o_first;
  assign result_out.last_result = o_last;

endmodule

`default_nettype wire

FILE: rtl/core/gsbs_ctrl.sv
// controller: sequences gap check, accumulate, block math and result transfers
`timescale 1ns / 1ps
`default_nettype none

module gsbs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  gsbs_pkg::status_t status,
  output gsbs_pkg::cmd_t    cmd
);

  gsbs_pkg::state_t state, state_next;
  gsbs_pkg::ctx_t   ctx, ctx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsbs_pkg::ST_IDLE;
      ctx   <= gsbs_pkg::CTX_GAP;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    cmd        = '0;
    unique case (state)
      gsbs_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = gsbs_pkg::ST_GAP;
        end
      end
      gsbs_pkg::ST_GAP: begin
        if (status.gap) begin
          ctx_next = gsbs_pkg::CTX_GAP;
          if (!status.fill_nz) begin
            state_next = gsbs_pkg::ST_EMIT_MARKER;
          end else if (status.under_three) begin
            state_next = gsbs_pkg::ST_EMIT_BLOCK;
          end else begin
            state_next = gsbs_pkg::ST_CALC_START;
          end
        end else begin
          state_next = gsbs_pkg::ST_ACCUM;
        end
      end
      gsbs_pkg::ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = gsbs_pkg::ST_FULL;
      end
      gsbs_pkg::ST_FULL: begin
        if (status.full) begin
          ctx_next   = gsbs_pkg::CTX_FULL;
          state_next = status.under_three ? gsbs_pkg::ST_EMIT_BLOCK : gsbs_pkg::ST_CALC_START;
        end else begin
          state_next = gsbs_pkg::ST_EOS;
        end
      end
      gsbs_pkg::ST_EOS: begin
        if (status.eos) begin
          ctx_next = gsbs_pkg::CTX_EOS;
          if (!status.fill_nz) begin
            state_next = gsbs_pkg::ST_EMIT_MARKER;
          end else if (status.under_three) begin
            state_next = gsbs_pkg::ST_EMIT_BLOCK;
          end else begin
            state_next = gsbs_pkg::ST_CALC_START;
          end
        end else begin
          state_next = gsbs_pkg::ST_IDLE;
        end
      end
      gsbs_pkg::ST_CALC_START: begin
        cmd.calc_start = 1'b1;
        state_next     = gsbs_pkg::ST_MUL;
      end
      gsbs_pkg::ST_MUL: begin
        // products and the mean divide run side by side
        cmd.mul_step = 1'b1;
        cmd.div_step = 1'b1;
        if (status.iter_done) begin
          state_next = gsbs_pkg::ST_SQRT_START;
        end
      end
      gsbs_pkg::ST_SQRT_START: begin
        cmd.sqrt_start = 1'b1;
        state_next     = gsbs_pkg::ST_SQRT;
      end
      gsbs_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.iter_done) begin
          state_next = gsbs_pkg::ST_DIV_START;
        end
      end
      gsbs_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = gsbs_pkg::ST_DIV;
      end
      gsbs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.iter_done) begin
          state_next = gsbs_pkg::ST_EMIT_BLOCK;
        end
      end
      gsbs_pkg::ST_EMIT_BLOCK: begin
        cmd.out_last = (ctx == gsbs_pkg::CTX_FULL) && !status.eos;
        if (status.out_free) begin
          cmd.out_load_block = 1'b1;
          unique case (ctx)
            gsbs_pkg::CTX_FULL: state_next = gsbs_pkg::ST_EOS;
            default:            state_next = gsbs_pkg::ST_EMIT_MARKER;
          endcase
        end
      end
      gsbs_pkg::ST_EMIT_MARKER: begin
        cmd.marker_prev = ctx == gsbs_pkg::CTX_GAP;
        // a gap marker is last only when the current sample adds nothing after it
        cmd.out_last = (ctx == gsbs_pkg::CTX_EOS) || (!status.eos && !status.size_one);
        if (status.out_free) begin
          cmd.out_load_marker = 1'b1;
          unique case (ctx)
            gsbs_pkg::CTX_GAP: state_next = gsbs_pkg::ST_ACCUM;
            default:           state_next = gsbs_pkg::ST_IDLE;
          endcase
        end
      end
      default: state_next = gsbs_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/gap_segmented_block_statistics.sv
// top level: gap-segmented block statistics engine
//
//  channel      dir  handshake       payload
//  sample_in    in   valid/ready     sample_time, sample_value, end_of_series
//  result_out   out  valid/ready     result_kind, block_time, min/max/mean, deviation,
//                                    first_value, last_result
//  cfg          in   cfg_we          cfg_index, cfg_data (no read-back)
//
//  one sample at a time
//  each block of three or more samples runs through the shared bit-serial multiply,
//  root and divide unit
//  each result is loaded into the output register and waits there on ready
//  synchronous active-high reset; no clearing pass, input ready held low during reset
`timescale 1ns / 1ps
`default_nettype none

module gap_segmented_block_statistics #(
  parameter int VALUE_WIDTH = gsbs_pkg::VALUE_WIDTH_DEF,
  parameter int FILL_WIDTH  = gsbs_pkg::FILL_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [gsbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [gsbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  gsbs_in_if.sink                                   sample_in,
  gsbs_out_if.source                                result_out
);

  gsbs_pkg::cmd_t    cmd;
  gsbs_pkg::status_t status;

  gsbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  gsbs_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FILL_WIDTH  (FILL_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (sample_in),
    .result_out (result_out)
  );

  // no block math while a new sample can be taken
  a_idle_no_math: assert property (@(posedge clk) disable iff (rst)
    sample_in.ready |-> !(cmd.mul_step || cmd.sqrt_step || cmd.div_step))
    else $error("block math active while accepting samples");

  // result register is only loaded when empty or draining
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load_block || cmd.out_load_marker) |-> status.out_free)
    else $error("result overwritten before transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
    else $error("second sample taken while one is in work");

  a_marker_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load_marker |=> !status.fill_nz)
    else $error("block fill not cleared at segment end");

endmodule

`default_nettype wire
